[rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

[rtl/cdsw_pkg.sv]
package cdsw_pkg;

  localparam int unsigned YearW = 14;
  localparam int unsigned MonW  = 4;
  localparam int unsigned DayW  = 5;
  localparam int unsigned WdW   = 3;
  localparam int unsigned CenW  = 7;
  localparam int unsigned LowW  = 7;
  localparam int unsigned BaseW = 10;

  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_NEXT = 2'd1;
  localparam logic [1:0] MODE_PREV = 2'd2;

  localparam logic [YearW-1:0] YEAR_MIN = 14'd1;
  localparam logic [YearW-1:0] YEAR_MAX = 14'd9999;
  localparam logic [YearW-1:0] YEAR_RST = 14'd2000;
  localparam logic [CenW-1:0]  CEN_RST  = 7'd20;
  localparam logic [LowW-1:0]  LOW_RST  = 7'd0;
  localparam logic [LowW-1:0]  LOW_MAX  = 7'd99;

  localparam logic [MonW-1:0] MON_JAN = 4'd1;
  localparam logic [MonW-1:0] MON_FEB = 4'd2;
  localparam logic [MonW-1:0] MON_MAR = 4'd3;
  localparam logic [MonW-1:0] MON_APR = 4'd4;
  localparam logic [MonW-1:0] MON_MAY = 4'd5;
  localparam logic [MonW-1:0] MON_JUN = 4'd6;
  localparam logic [MonW-1:0] MON_JUL = 4'd7;
  localparam logic [MonW-1:0] MON_AUG = 4'd8;
  localparam logic [MonW-1:0] MON_SEP = 4'd9;
  localparam logic [MonW-1:0] MON_OCT = 4'd10;
  localparam logic [MonW-1:0] MON_NOV = 4'd11;
  localparam logic [MonW-1:0] MON_DEC = 4'd12;

  localparam logic [DayW-1:0] DAY_FIRST = 5'd1;
  localparam logic [DayW-1:0] DAY_DEC_LAST = 5'd31;

  // year / 100 as (year * 5243) >> 19, exact for any 14-bit year
  localparam int unsigned   Div100Shift = 19;
  localparam logic [12:0]   DIV100_MUL  = 13'd5243;
  localparam logic [YearW-1:0] CENTURY  = 14'd100;

  localparam logic [BaseW-1:0] ZELLER_BIAS = 10'd6;

  typedef struct packed {
    logic [YearW-1:0] year;
    logic [MonW-1:0]  month;
    logic [DayW-1:0]  day;
    logic [DayW-1:0]  mlen;
    logic             err;
    logic [BaseW-1:0] base;
  } c_stage_t;

  typedef struct packed {
    logic             err;
    logic [DayW-1:0]  mlen;
    logic [WdW-1:0]   first_wd;
    logic [WdW-1:0]   week_wd;
    logic [DayW-1:0]  day;
    logic [MonW-1:0]  month;
    logic [YearW-1:0] year;
  } result_t;

  function automatic logic is_leap(input logic [7:0] cen, input logic [LowW-1:0] low);
    return (low[1:0] == 2'b00) && ((low != '0) || (cen[1:0] == 2'b00));
  endfunction

  function automatic logic [DayW-1:0] month_len(input logic [MonW-1:0] mon,
                                                input logic leap);
    logic [DayW-1:0] len;
    unique case (mon)
      MON_FEB: len = leap ? 5'd29 : 5'd28;
      MON_APR, MON_JUN, MON_SEP, MON_NOV: len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

  // floor(26 * (m + 1) / 10) with jan and feb counted as months 13 and 14
  function automatic logic [5:0] zeller_month(input logic [MonW-1:0] mon);
    logic [5:0] z;
    unique case (mon)
      MON_JAN: z = 6'd36;
      MON_FEB: z = 6'd39;
      MON_MAR: z = 6'd10;
      MON_APR: z = 6'd13;
      MON_MAY: z = 6'd15;
      MON_JUN: z = 6'd18;
      MON_JUL: z = 6'd20;
      MON_AUG: z = 6'd23;
      MON_SEP: z = 6'd26;
      MON_OCT: z = 6'd28;
      MON_NOV: z = 6'd31;
      MON_DEC: z = 6'd33;
      default: z = 6'd0;
    endcase
    return z;
  endfunction

  // octal digit folding, since 8 is 1 modulo 7
  function automatic logic [WdW-1:0] mod7(input logic [BaseW-1:0] x);
    logic [4:0] s1;
    logic [3:0] s2;
    s1 = 5'(x[2:0]) + 5'(x[5:3]) + 5'(x[8:6]) + 5'(x[9]);
    s2 = 4'(s1[2:0]) + 4'(s1[4:3]);
    return (s2 >= 4'd7) ? 3'(s2 - 4'd7) : s2[2:0];
  endfunction

endpackage

[rtl/calendar_date_step_weekday.sv]
// throughput: one request per cycle; input register, date update, weekday sum
// and result register form a four-deep pipeline, ready drops only when all
// four stages hold a request and the result is not taken
// reset: date is 2000-01-01 and the pipeline is empty
`include "assert_macros.svh"

module calendar_date_step_weekday
  import cdsw_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // mode[1:0], load_year[15:2], load_month[19:16], load_day[24:20]
  input  logic [31:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // cur_year[13:0], cur_month[17:14], cur_day[22:18], week_day[25:23],
  // first_week_day[28:26], month_length[33:29], range_error[34]
  output logic [39:0] m_axis_tdata_o
);

  logic a_en, b_en, c_en, d_en;

  // input stage
  logic [1:0]       in_mode;
  logic [YearW-1:0] in_year;
  logic [MonW-1:0]  in_month;
  logic [DayW-1:0]  in_day;
  logic [26:0]      in_prod;
  logic [7:0]       in_cen;
  logic [LowW-1:0]  in_low;

  logic             a_v_q;
  logic [1:0]       a_mode_q;
  logic [YearW-1:0] a_year_q;
  logic [MonW-1:0]  a_month_q;
  logic [DayW-1:0]  a_day_q;
  logic [7:0]       a_cen_q;
  logic [LowW-1:0]  a_low_q;

  // date state, also the payload of the update stage
  logic             b_v_q;
  logic             b_err_q, b_err_d;
  logic [YearW-1:0] year_q, year_d;
  logic [CenW-1:0]  cen_q, cen_d;
  logic [LowW-1:0]  low_q, low_d;
  logic [MonW-1:0]  month_q, month_d;
  logic [DayW-1:0]  day_q, day_d;

  logic             cur_leap;
  logic [DayW-1:0]  cur_len, prv_len, ld_len;
  logic             ld_ok;
  logic [CenW-1:0]  inc_cen, dec_cen;
  logic [LowW-1:0]  inc_low, dec_low;

  // weekday sum stage
  logic             c_v_q;
  c_stage_t         c_q, c_d;
  logic [CenW-1:0]  z_cen;
  logic [LowW-1:0]  z_low;

  // result stage
  logic             d_v_q;
  result_t          d_q, d_d;

  assign d_en = !d_v_q || m_axis_tready_i;
  assign c_en = !c_v_q || d_en;
  assign b_en = !b_v_q || c_en;
  assign a_en = !a_v_q || b_en;

  assign s_axis_tready_o = a_en;

  assign in_mode  = s_axis_tdata_i[1:0];
  assign in_year  = s_axis_tdata_i[15:2];
  assign in_month = s_axis_tdata_i[19:16];
  assign in_day   = s_axis_tdata_i[24:20];
  assign in_prod  = 27'(in_year) * 27'(DIV100_MUL);
  assign in_cen   = in_prod[26:Div100Shift];
  assign in_low   = LowW'(in_year - 14'(in_cen) * CENTURY);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else if (a_en) begin
      a_v_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_en && s_axis_tvalid_i) begin
      a_mode_q  <= in_mode;
      a_year_q  <= in_year;
      a_month_q <= in_month;
      a_day_q   <= in_day;
      a_cen_q   <= in_cen;
      a_low_q   <= in_low;
    end
  end

  assign cur_leap = is_leap({1'b0, cen_q}, low_q);
  assign cur_len  = month_len(month_q, cur_leap);
  assign prv_len  = month_len(month_q - 4'd1, cur_leap);
  assign ld_len   = month_len(a_month_q, is_leap(a_cen_q, a_low_q));
  assign ld_ok    = (a_year_q >= YEAR_MIN) && (a_year_q <= YEAR_MAX) &&
                    (a_month_q >= MON_JAN) && (a_month_q <= MON_DEC) &&
                    (a_day_q >= DAY_FIRST) && (a_day_q <= ld_len);

  assign inc_low = (low_q == LOW_MAX) ? '0 : low_q + 7'd1;
  assign inc_cen = (low_q == LOW_MAX) ? cen_q + 7'd1 : cen_q;
  assign dec_low = (low_q == '0) ? LOW_MAX : low_q - 7'd1;
  assign dec_cen = (low_q == '0) ? cen_q - 7'd1 : cen_q;

  always_comb begin
    year_d  = year_q;
    cen_d   = cen_q;
    low_d   = low_q;
    month_d = month_q;
    day_d   = day_q;
    b_err_d = 1'b0;
    unique case (a_mode_q)
      MODE_LOAD: begin
        if (ld_ok) begin
          year_d  = a_year_q;
          cen_d   = a_cen_q[CenW-1:0];
          low_d   = a_low_q;
          month_d = a_month_q;
          day_d   = a_day_q;
        end else begin
          b_err_d = 1'b1;
        end
      end
      MODE_NEXT: begin
        priority if (day_q < cur_len) begin
          day_d = day_q + 5'd1;
        end else if (month_q < MON_DEC) begin
          month_d = month_q + 4'd1;
          day_d   = DAY_FIRST;
        end else if (year_q < YEAR_MAX) begin
          year_d  = year_q + 14'd1;
          cen_d   = inc_cen;
          low_d   = inc_low;
          month_d = MON_JAN;
          day_d   = DAY_FIRST;
        end else begin
          b_err_d = 1'b1;
        end
      end
      MODE_PREV: begin
        priority if (day_q > DAY_FIRST) begin
          day_d = day_q - 5'd1;
        end else if (month_q > MON_JAN) begin
          month_d = month_q - 4'd1;
          day_d   = prv_len;
        end else if (year_q > YEAR_MIN) begin
          year_d  = year_q - 14'd1;
          cen_d   = dec_cen;
          low_d   = dec_low;
          month_d = MON_DEC;
          day_d   = DAY_DEC_LAST;
        end else begin
          b_err_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q   <= 1'b0;
      b_err_q <= 1'b0;
      year_q  <= YEAR_RST;
      cen_q   <= CEN_RST;
      low_q   <= LOW_RST;
      month_q <= MON_JAN;
      day_q   <= DAY_FIRST;
    end else if (b_en) begin
      b_v_q <= a_v_q;
      if (a_v_q) begin
        b_err_q <= b_err_d;
        year_q  <= year_d;
        cen_q   <= cen_d;
        low_q   <= low_d;
        month_q <= month_d;
        day_q   <= day_d;
      end
    end
  end

  // jan and feb belong to the previous year in the congruence
  always_comb begin
    z_cen = cen_q;
    z_low = low_q;
    if (month_q < MON_MAR) begin
      z_cen = dec_cen;
      z_low = dec_low;
    end
    c_d.year  = year_q;
    c_d.month = month_q;
    c_d.day   = day_q;
    c_d.mlen  = cur_len;
    c_d.err   = b_err_q;
    c_d.base  = 10'(z_cen[CenW-1:2]) + 10'({z_cen, 2'b00}) + 10'(z_cen)
              + 10'(z_low) + 10'(z_low[LowW-1:2]) + 10'(zeller_month(month_q))
              + ZELLER_BIAS;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_v_q <= 1'b0;
    end else if (c_en) begin
      c_v_q <= b_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_en && b_v_q) begin
      c_q <= c_d;
    end
  end

  always_comb begin
    d_d.year     = c_q.year;
    d_d.month    = c_q.month;
    d_d.day      = c_q.day;
    d_d.week_wd  = mod7(c_q.base + 10'(c_q.day));
    d_d.first_wd = mod7(c_q.base + 10'(DAY_FIRST));
    d_d.mlen     = c_q.mlen;
    d_d.err      = c_q.err;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_v_q <= 1'b0;
    end else if (d_en) begin
      d_v_q <= c_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (d_en && c_v_q) begin
      d_q <= d_d;
    end
  end

  assign m_axis_tvalid_o = d_v_q;
  assign m_axis_tdata_o  = {5'd0, d_q};

  logic [YearW-1:0] year_chk;
  logic             date_ok;
  logic             split_ok;
  logic             all_busy;
  assign year_chk = 14'(cen_q) * CENTURY + 14'(low_q);
  assign date_ok  = (month_q >= MON_JAN) && (month_q <= MON_DEC) &&
                    (day_q >= DAY_FIRST) && (day_q <= cur_len);
  assign split_ok = (year_chk == year_q) && (low_q <= LOW_MAX);
  assign all_busy = a_v_q && b_v_q && c_v_q && d_v_q;

  `ASSERT_CLK(a_date_legal, date_ok, "stored date is not a calendar date")
  `ASSERT_CLK(a_year_split, split_ok, "century split does not match year")
  `ASSERT_NEVER(a_full_stall, !s_axis_tready_o && !all_busy, "request refused with a free stage")

endmodule
